// File: src/ssc_pkg.sv
// Shared types and constants for the substring search counter.
`default_nettype none
package ssc_pkg;

  localparam int TEXT_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_CFG_W  = 4;
  localparam int OUT_W      = 16;

  typedef logic [TEXT_W-1:0]     text_t;
  typedef logic [OUT_W-1:0]      out_word_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [LEN_CFG_W-1:0]  len_cfg_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

endpackage : ssc_pkg
`default_nettype wire

// File: src/ssc_if.sv
// Valid/ready channel interfaces for text requests and search results.
`default_nettype none
interface ssc_in_if
  import ssc_pkg::*;
();
  logic  valid;
  logic  ready;
  text_t text_byte;
  logic  is_last;

  modport source (output valid, text_byte, is_last, input ready);
  modport sink   (input valid, text_byte, is_last, output ready);
endinterface : ssc_in_if

interface ssc_out_if
  import ssc_pkg::*;
();
  logic      valid;
  logic      ready;
  logic      found;
  out_word_t first_index;
  out_word_t hit_total;

  modport source (output valid, found, first_index, hit_total, input ready);
  modport sink   (input valid, found, first_index, hit_total, output ready);
endinterface : ssc_out_if
`default_nettype wire

// File: src/substring_search_count_core.sv
// Streaming substring search: first match offset and non-overlapping match count.
// A request carrying is_last is taken into the input register; its result is
//   then loaded into the result register, which drives the output.
// Throughput: one text byte per cycle; a last byte waits in the input register
//   only while an unread result still holds the output register.
// Reset (rst_n low, synchronous): pattern length 0, pattern 0, stream cleared.
`default_nettype none
module substring_search_count_core
  import ssc_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int INDEX_BITS        = 16
) (
  input  wire            clk,
  input  wire            rst_n,
  ssc_in_if.sink         in_req,
  ssc_out_if.source      out_res,
  input  wire            cfg_we,
  input  wire cfg_reg_t  cfg_index,
  input  wire cfg_data_t cfg_wdata
);

  localparam int WIN_W = MAX_PATTERN_BYTES * TEXT_W;      // window and pattern width
  localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);   // clamped length width
  localparam int CMP_W = (INDEX_BITS > OUT_W) ? INDEX_BITS : OUT_W;

  typedef logic [INDEX_BITS-1:0] idx_t;

  // Clamp an index value to the 16-bit output range.
  function automatic out_word_t clamp_out(input idx_t v);
    if (CMP_W'(v) > CMP_W'({OUT_W{1'b1}})) begin
      return {OUT_W{1'b1}};
    end
    return OUT_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0] pattern_r;
  len_cfg_t         pattern_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r     <= '0;
      pattern_len_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:  pattern_r     <= cfg_wdata[WIN_W-1:0];
        CFG_PATTERN_LENGTH: pattern_len_r <= cfg_wdata[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the window depth act as the full window.
  logic [LEN_W-1:0] len_c;
  assign len_c = (pattern_len_r > LEN_CFG_W'(MAX_PATTERN_BYTES))
                 ? LEN_W'(MAX_PATTERN_BYTES) : LEN_W'(pattern_len_r);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic  s1_v_r;
  text_t s1_byte_r;
  logic  s1_last_r;
  logic  out_v_r;
  logic  advance;
  logic  in_fire;

  // A non-last byte never needs the result register, so it always moves on.
  assign advance = s1_v_r && (!s1_last_r || !out_v_r || out_res.ready);
  assign in_req.ready = !s1_v_r || advance;
  assign in_fire = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_req.text_byte;
      s1_last_r <= in_req.is_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Search stage: window shift, parallel compare, counter update
  // ---------------------------------------------------------------------------
  logic [WIN_W-1:0] window_r, window_nxt;
  idx_t             pos_r, pos_nxt;
  logic             seen_r, seen_nxt;
  idx_t             first_r, first_nxt;
  idx_t             count_r, count_nxt;
  logic [LEN_W-1:0] ob_r, ob_nxt;

  logic [INDEX_BITS:0]        pos_plus1;
  logic [MAX_PATTERN_BYTES-1:0] len_hit;
  logic                       sel_hit;
  logic                       hit;

  // Newest byte lands in the low byte.
  assign window_nxt = WIN_W'({window_r, s1_byte_r});
  assign pos_plus1  = {1'b0, pos_r} + (INDEX_BITS+1)'(1);

  // len_hit[l-1]: newest l window bytes equal the first l pattern bytes.
  always_comb begin
    len_hit = '1;
    for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
      for (int k = 0; k < l; k++) begin
        if (pattern_r[TEXT_W*k +: TEXT_W] != window_nxt[TEXT_W*(l-1-k) +: TEXT_W]) begin
          len_hit[l-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    sel_hit = 1'b0;
    for (int l = 1; l <= MAX_PATTERN_BYTES; l++) begin
      if (len_c == LEN_W'(l)) begin
        sel_hit = len_hit[l-1];
      end
    end
  end

  // Needs at least len bytes of this text.
  assign hit = (len_c != '0) && (pos_plus1 >= (INDEX_BITS+1)'(len_c)) && sel_hit;

  always_comb begin
    seen_nxt  = seen_r;
    first_nxt = first_r;
    count_nxt = count_r;
    ob_nxt    = ob_r;
    pos_nxt   = pos_r;

    if (hit && !seen_r) begin
      seen_nxt  = 1'b1;
      first_nxt = INDEX_BITS'(pos_plus1 - (INDEX_BITS+1)'(len_c));
    end

    // Greedy non-overlapping count: block len-1 bytes after a counted match.
    if (ob_r != '0) begin
      ob_nxt = ob_r - LEN_W'(1);
    end else if (hit) begin
      if (count_r != '1) begin
        count_nxt = count_r + INDEX_BITS'(1);
      end
      ob_nxt = len_c - LEN_W'(1);
    end

    if (pos_r != '1) begin
      pos_nxt = INDEX_BITS'(pos_plus1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      pos_r    <= '0;
      seen_r   <= 1'b0;
      first_r  <= '0;
      count_r  <= '0;
      ob_r     <= '0;
    end else if (advance) begin
      if (s1_last_r) begin
        // end of text: clear for the next one
        window_r <= '0;
        pos_r    <= '0;
        seen_r   <= 1'b0;
        first_r  <= '0;
        count_r  <= '0;
        ob_r     <= '0;
      end else begin
        window_r <= window_nxt;
        pos_r    <= pos_nxt;
        seen_r   <= seen_nxt;
        first_r  <= first_nxt;
        count_r  <= count_nxt;
        ob_r     <= ob_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic      out_found_r;
  out_word_t out_first_r;
  out_word_t out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_found_r <= seen_nxt;
      out_first_r <= seen_nxt ? clamp_out(first_nxt) : '0;
      out_count_r <= clamp_out(count_nxt);
    end
  end

  assign out_res.valid       = out_v_r;
  assign out_res.found       = out_found_r;
  assign out_res.first_index = out_first_r;
  assign out_res.hit_total   = out_count_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_found_r |-> out_count_r == '0 && out_first_r == '0)
    else $error("result without match carries nonzero index or count");

  a_found_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_found_r |-> out_count_r != '0)
    else $error("first match was not counted");

  a_state_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !seen_r |-> count_r == '0 && first_r == '0)
    else $error("count or offset set before any match");

  a_last_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> out_v_r)
    else $error("last byte retired without a result");

  a_block_range: assert property (@(posedge clk) disable iff (!rst_n)
    ob_r < LEN_W'(MAX_PATTERN_BYTES))
    else $error("overlap block beyond pattern length");

endmodule : substring_search_count_core
`default_nettype wire
